// ===== hdl/json_stream_validator_defines.svh =====
// Assertion helpers shared by the validator RTL.
`ifndef JSON_STREAM_VALIDATOR_DEFINES_SVH
`define JSON_STREAM_VALIDATOR_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define JSV_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("json_stream_validator check failed");

// Property whose consequent must hold in the cycle after the antecedent.
`define JSV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("json_stream_validator check failed");

`endif

// ===== hdl/jsv_pkg.sv =====
package jsv_pkg;

  localparam int MAX_DEPTH = 128;
  localparam int STACK_AW = $clog2(MAX_DEPTH);
  localparam logic [15:0] LEN_MAX = 16'hFFFF;
  localparam logic [7:0] DEPTH_CAP = 8'(MAX_DEPTH);
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);

  // Token kinds.
  localparam logic [3:0] K_LBRACE = 4'd0;
  localparam logic [3:0] K_RBRACE = 4'd1;
  localparam logic [3:0] K_LBRACKET = 4'd2;
  localparam logic [3:0] K_RBRACKET = 4'd3;
  localparam logic [3:0] K_COLON = 4'd4;
  localparam logic [3:0] K_COMMA = 4'd5;
  localparam logic [3:0] K_STRING = 4'd6;
  localparam logic [3:0] K_NUMBER = 4'd7;
  localparam logic [3:0] K_TRUE = 4'd8;
  localparam logic [3:0] K_FALSE = 4'd9;
  localparam logic [3:0] K_NULL = 4'd10;
  localparam logic [3:0] K_NONE = 4'd11;

  // Status codes.
  localparam logic [2:0] ST_TOKEN = 3'd0;
  localparam logic [2:0] ST_ACCEPT = 3'd1;
  localparam logic [2:0] ST_SYNTAX = 3'd2;
  localparam logic [2:0] ST_BAD_CHAR = 3'd3;
  localparam logic [2:0] ST_BAD_ESC = 3'd4;
  localparam logic [2:0] ST_BAD_NUM = 3'd5;
  localparam logic [2:0] ST_TOO_DEEP = 3'd6;
  localparam logic [2:0] ST_EARLY_END = 3'd7;

  // Lexer states.
  localparam logic [3:0] L_IDLE = 4'd0;
  localparam logic [3:0] L_STR = 4'd1;
  localparam logic [3:0] L_ESC = 4'd2;
  localparam logic [3:0] L_HEX = 4'd3;
  localparam logic [3:0] L_KW_T = 4'd4;
  localparam logic [3:0] L_KW_F = 4'd5;
  localparam logic [3:0] L_KW_N = 4'd6;
  localparam logic [3:0] L_MINUS = 4'd7;
  localparam logic [3:0] L_ZERO = 4'd8;
  localparam logic [3:0] L_INT = 4'd9;
  localparam logic [3:0] L_DOT = 4'd10;
  localparam logic [3:0] L_FRAC = 4'd11;
  localparam logic [3:0] L_E = 4'd12;
  localparam logic [3:0] L_ESIGN = 4'd13;
  localparam logic [3:0] L_EXP = 4'd14;
  localparam logic [3:0] L_ERR = 4'd15;

  // Grammar states.
  localparam logic [2:0] G_TOP = 3'd0;
  localparam logic [2:0] G_VALUE = 3'd1;
  localparam logic [2:0] G_ARR_FIRST = 3'd2;
  localparam logic [2:0] G_OBJ_FIRST = 3'd3;
  localparam logic [2:0] G_KEY = 3'd4;
  localparam logic [2:0] G_COLON = 3'd5;
  localparam logic [2:0] G_AFTER = 3'd6;
  localparam logic [2:0] G_DONE = 3'd7;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] length;
    logic [7:0]  depth;
    logic [2:0]  status;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [2:0] code;
    logic [2:0] gst;
    logic [7:0] depth;
    logic       push;
    logic       pbit;
  } gram_t;

endpackage

// ===== hdl/jsv_stack.sv =====
module jsv_stack (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [jsv_pkg::STACK_AW-1:0] wr_addr,
  input  logic                         wr_data,
  input  logic [jsv_pkg::STACK_AW-1:0] rd_addr,
  output logic                         rd_data
);
  import jsv_pkg::*;

  logic mem [MAX_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // A write to the entry being read returns the new bit.
  always_ff @(posedge clk) begin
    if (wr_en && wr_addr == rd_addr) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/json_stream_validator.sv =====
// Results are queued when their byte is taken and are offered in order from the queue head.
// Throughput: one byte per cycle; each byte yields up to two results through
// a four-entry result queue, and input stalls while fewer than two slots are free.
// The container stack is a 1-bit memory whose registered read is addressed at the new top.
// Reset (rst, synchronous) clears all control state and sets the limit to DEPTH_CAP; the stack holds no reset.
// End of document reports the final status and returns the parser to its reset state.
`include "json_stream_validator_defines.svh"

module json_stream_validator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_document,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  token_kind,
  output logic [15:0] token_length,
  output logic [7:0]  nesting_depth,
  output logic [2:0]  status,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  nesting_limit
);
  import jsv_pkg::*;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic [7:0] kw_char(input logic [1:0] sel, input logic [2:0] p);
    logic [7:0] ch;
    ch = 8'h00;
    case (sel)
      2'd0: ch = (p == 3'd1) ? "r" : (p == 3'd2) ? "u" : "e";
      2'd1: ch = (p == 3'd1) ? "a" : (p == 3'd2) ? "l" : (p == 3'd3) ? "s" : "e";
      default: ch = (p == 3'd1) ? "u" : "l";
    endcase
    return ch;
  endfunction

  function automatic res_t mk(input logic [3:0] k, input logic [15:0] l,
                              input logic [7:0] d, input logic [2:0] s);
    res_t r;
    r.kind = k;
    r.length = l;
    r.depth = d;
    r.status = s;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic gram_t gram(input logic [3:0] kind, input logic [2:0] g,
                                 input logic [7:0] d, input logic [7:0] lim,
                                 input logic top_obj);
    gram_t r;
    logic scalar;
    r.code = ST_SYNTAX;
    r.gst = g;
    r.depth = d;
    r.push = 1'b0;
    r.pbit = (kind == K_LBRACE);
    scalar = kind >= K_STRING && kind <= K_NULL;
    if (g inside {G_TOP, G_VALUE, G_ARR_FIRST, G_OBJ_FIRST}) begin
      if (g == G_OBJ_FIRST && kind == K_STRING) begin
        r.code = ST_TOKEN;
        r.gst = G_COLON;
      end else if (g != G_OBJ_FIRST && scalar) begin
        r.code = ST_TOKEN;
        r.gst = (d == 8'd0) ? G_DONE : G_AFTER;
      end else if (kind == K_LBRACE || kind == K_LBRACKET) begin
        if (g == G_OBJ_FIRST) begin
          r.code = ST_SYNTAX;
        end else if (d >= lim) begin
          r.code = ST_TOO_DEEP;
        end else begin
          r.code = ST_TOKEN;
          r.push = 1'b1;
          r.depth = d + 8'd1;
          r.gst = (kind == K_LBRACE) ? G_OBJ_FIRST : G_ARR_FIRST;
        end
      end else if ((g == G_ARR_FIRST && kind == K_RBRACKET) ||
                   (g == G_OBJ_FIRST && kind == K_RBRACE)) begin
        r.code = ST_TOKEN;
        r.depth = d - 8'd1;
        r.gst = (d == 8'd1) ? G_DONE : G_AFTER;
      end
    end else if (g == G_KEY) begin
      if (kind == K_STRING) begin
        r.code = ST_TOKEN;
        r.gst = G_COLON;
      end
    end else if (g == G_COLON) begin
      if (kind == K_COLON) begin
        r.code = ST_TOKEN;
        r.gst = G_VALUE;
      end
    end else if (g == G_AFTER && d != 8'd0) begin
      if (kind == K_COMMA) begin
        r.code = ST_TOKEN;
        r.gst = top_obj ? G_KEY : G_VALUE;
      end else if ((kind == K_RBRACE && top_obj) || (kind == K_RBRACKET && !top_obj)) begin
        r.code = ST_TOKEN;
        r.depth = d - 8'd1;
        r.gst = (d == 8'd1) ? G_DONE : G_AFTER;
      end
    end
    return r;
  endfunction

  logic [7:0]  limit;
  logic [7:0]  lim;
  logic [3:0]  lex, lex_next;
  logic [2:0]  kwp, kwp_next;
  logic [2:0]  hexl, hexl_next;
  logic [15:0] len, len_next, len_bump;
  logic [2:0]  gst, gst_next;
  logic [7:0]  depth, depth_next;
  logic [2:0]  err, err_next;

  logic                take;
  logic                wr_en, wr_data, rd_data, top_obj;
  logic [STACK_AW-1:0] wr_addr, rd_addr;

  res_t       q [2];
  logic [1:0] nq;
  logic [7:0] c;
  logic [1:0] sel;
  logic [2:0] klen;
  logic       tok_a, tok_b, idle_again, lfail;
  logic [3:0] ka, kb;
  logic [2:0] lcode, fin;
  gram_t      ga, gb;

  res_t               fifo [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr, rptr;
  logic [FIFO_AW:0]   count, count_next;
  logic               pop;

  assign cfg_ready = 1'b1;
  assign lim = (limit > DEPTH_CAP) ? DEPTH_CAP : limit;
  assign take = in_valid && !in_stall;
  assign top_obj = (depth != 8'd0) && rd_data;
  assign len_bump = (len == LEN_MAX) ? len : len + 16'd1;
  assign rd_addr = STACK_AW'(depth_next - 8'd1);

  jsv_stack u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    lex_next = lex;
    kwp_next = kwp;
    hexl_next = hexl;
    len_next = len;
    gst_next = gst;
    depth_next = depth;
    err_next = err;
    q[0] = '0;
    q[1] = '0;
    nq = 2'd0;
    wr_en = 1'b0;
    wr_addr = depth[STACK_AW-1:0];
    wr_data = 1'b0;
    c = data_byte;
    sel = (lex == L_KW_F) ? 2'd1 : (lex == L_KW_N) ? 2'd2 : 2'd0;
    klen = (sel == 2'd1) ? 3'd5 : 3'd4;
    tok_a = 1'b0;
    tok_b = 1'b0;
    ka = K_NONE;
    kb = K_NONE;
    idle_again = 1'b0;
    lfail = 1'b0;
    lcode = ST_SYNTAX;
    ga = '0;
    gb = '0;
    fin = ST_EARLY_END;

    if (take) begin
      if (end_of_document) begin
        // A complete number or keyword still pending is reported first.
        if (lex inside {L_ZERO, L_INT, L_FRAC, L_EXP}) begin
          lex_next = L_IDLE;
          tok_a = 1'b1;
          ka = K_NUMBER;
        end else if (lex inside {L_KW_T, L_KW_F, L_KW_N} && kwp == klen) begin
          lex_next = L_IDLE;
          tok_a = 1'b1;
          ka = K_TRUE + 4'(sel);
        end
      end else begin
        case (lex)
          L_ERR: ;
          L_IDLE: idle_again = 1'b1;
          L_STR: begin
            if (c == "\"") begin
              lex_next = L_IDLE;
              tok_a = 1'b1;
              ka = K_STRING;
            end else if (c == "\\") begin
              len_next = len_bump;
              lex_next = L_ESC;
            end else if (c < 8'h20) begin
              lfail = 1'b1;
              lcode = ST_BAD_CHAR;
            end else begin
              len_next = len_bump;
            end
          end
          L_ESC: begin
            if (c == "u") begin
              len_next = len_bump;
              hexl_next = 3'd4;
              lex_next = L_HEX;
            end else if (c inside {"\"", "\\", "/", "b", "f", "n", "r", "t"}) begin
              len_next = len_bump;
              lex_next = L_STR;
            end else begin
              lfail = 1'b1;
              lcode = ST_BAD_ESC;
            end
          end
          L_HEX: begin
            if (!is_hex(c)) begin
              lfail = 1'b1;
              lcode = ST_BAD_ESC;
            end else begin
              len_next = len_bump;
              hexl_next = hexl - 3'd1;
              if (hexl == 3'd1) begin
                lex_next = L_STR;
              end
            end
          end
          L_KW_T, L_KW_F, L_KW_N: begin
            if (kwp < klen) begin
              if (c == kw_char(sel, kwp)) begin
                kwp_next = kwp + 3'd1;
                len_next = len_bump;
              end else begin
                lfail = 1'b1;
                lcode = ST_BAD_CHAR;
              end
            end else if (is_alnum(c)) begin
              lfail = 1'b1;
              lcode = ST_BAD_CHAR;
            end else begin
              lex_next = L_IDLE;
              tok_a = 1'b1;
              ka = K_TRUE + 4'(sel);
              idle_again = 1'b1;
            end
          end
          L_MINUS, L_DOT, L_ESIGN: begin
            if (is_digit(c)) begin
              len_next = len_bump;
              if (lex == L_MINUS) begin
                lex_next = (c == "0") ? L_ZERO : L_INT;
              end else begin
                lex_next = (lex == L_DOT) ? L_FRAC : L_EXP;
              end
            end else begin
              lfail = 1'b1;
              lcode = ST_BAD_NUM;
            end
          end
          L_E: begin
            if (c == "+" || c == "-") begin
              len_next = len_bump;
              lex_next = L_ESIGN;
            end else if (is_digit(c)) begin
              len_next = len_bump;
              lex_next = L_EXP;
            end else begin
              lfail = 1'b1;
              lcode = ST_BAD_NUM;
            end
          end
          default: begin
            if (is_digit(c) && lex != L_ZERO) begin
              len_next = len_bump;
            end else if (c == "." && (lex == L_ZERO || lex == L_INT)) begin
              len_next = len_bump;
              lex_next = L_DOT;
            end else if ((c == "e" || c == "E") && lex != L_EXP) begin
              len_next = len_bump;
              lex_next = L_E;
            end else begin
              lex_next = L_IDLE;
              tok_a = 1'b1;
              ka = K_NUMBER;
              idle_again = 1'b1;
            end
          end
        endcase
      end

      if (lfail) begin
        err_next = lcode;
        lex_next = L_ERR;
        q[nq[0]] = mk(K_NONE, 16'd0, depth_next, lcode);
        nq = nq + 2'd1;
      end

      if (tok_a) begin
        ga = gram(ka, gst_next, depth_next, lim, top_obj);
        if (ga.code != ST_TOKEN) begin
          err_next = ga.code;
          lex_next = L_ERR;
          q[nq[0]] = mk(K_NONE, 16'd0, depth_next, ga.code);
        end else begin
          gst_next = ga.gst;
          depth_next = ga.depth;
          q[nq[0]] = mk(ka, len, depth_next, ST_TOKEN);
        end
        nq = nq + 2'd1;
      end

      // A byte taken while idle, or the byte that ended a number or keyword, starts over as a fresh byte.
      if (idle_again && err_next == 3'd0 &&
          !(c == " " || c == 8'h09 || c == 8'h0A || c == 8'h0D)) begin
        if (gst_next == G_DONE) begin
          lfail = 1'b1;
          lcode = ST_SYNTAX;
        end else begin
          len_next = 16'd0;
          case (c)
            "{": begin tok_b = 1'b1; kb = K_LBRACE; end
            "}": begin tok_b = 1'b1; kb = K_RBRACE; end
            "[": begin tok_b = 1'b1; kb = K_LBRACKET; end
            "]": begin tok_b = 1'b1; kb = K_RBRACKET; end
            ":": begin tok_b = 1'b1; kb = K_COLON; end
            ",": begin tok_b = 1'b1; kb = K_COMMA; end
            "\"": lex_next = L_STR;
            "t", "f", "n": begin
              lex_next = (c == "t") ? L_KW_T : (c == "f") ? L_KW_F : L_KW_N;
              kwp_next = 3'd1;
              len_next = 16'd1;
            end
            "-": begin
              lex_next = L_MINUS;
              len_next = 16'd1;
            end
            "0": begin
              lex_next = L_ZERO;
              len_next = 16'd1;
            end
            default: begin
              if (is_digit(c)) begin
                lex_next = L_INT;
                len_next = 16'd1;
              end else begin
                lfail = 1'b1;
                lcode = ST_BAD_CHAR;
              end
            end
          endcase
        end
        if (lfail) begin
          err_next = lcode;
          lex_next = L_ERR;
          q[nq[0]] = mk(K_NONE, 16'd0, depth_next, lcode);
          nq = nq + 2'd1;
        end
        if (tok_b) begin
          gb = gram(kb, gst_next, depth_next, lim, top_obj);
          if (gb.code != ST_TOKEN) begin
            err_next = gb.code;
            lex_next = L_ERR;
            q[nq[0]] = mk(K_NONE, 16'd0, depth_next, gb.code);
          end else begin
            wr_en = gb.push;
            wr_addr = depth_next[STACK_AW-1:0];
            wr_data = gb.pbit;
            gst_next = gb.gst;
            depth_next = gb.depth;
            q[nq[0]] = mk(kb, 16'd1, depth_next, ST_TOKEN);
          end
          nq = nq + 2'd1;
        end
      end

      if (end_of_document) begin
        if (err_next != 3'd0) begin
          fin = err_next;
        end else if (lex_next == L_IDLE && gst_next == G_DONE) begin
          fin = ST_ACCEPT;
        end else begin
          fin = ST_EARLY_END;
        end
        q[nq[0]] = mk(K_NONE, 16'd0, depth_next, fin);
        nq = nq + 2'd1;
        lex_next = L_IDLE;
        kwp_next = 3'd0;
        hexl_next = 3'd0;
        len_next = 16'd0;
        gst_next = G_TOP;
        depth_next = 8'd0;
        err_next = 3'd0;
      end

      if (nq == 2'd1) begin
        q[0].last = 1'b1;
      end else if (nq == 2'd2) begin
        q[1].last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lex <= L_IDLE;
      kwp <= 3'd0;
      hexl <= 3'd0;
      len <= 16'd0;
      gst <= G_TOP;
      depth <= 8'd0;
      err <= 3'd0;
      limit <= DEPTH_CAP;
    end else begin
      lex <= lex_next;
      kwp <= kwp_next;
      hexl <= hexl_next;
      len <= len_next;
      gst <= gst_next;
      depth <= depth_next;
      err <= err_next;
      if (cfg_valid && cfg_ready) begin
        limit <= nesting_limit;
      end
    end
  end

  // Result queue: up to two writes per accepted byte, one read per cycle while out_stall is low.
  assign pop = out_valid && !out_stall;
  assign in_stall = count > (FIFO_AW + 1)'(FIFO_DEPTH - 2);
  assign count_next = count + (take ? (FIFO_AW + 1)'(nq) : '0) - (pop ? 1'b1 : 1'b0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (take) begin
        wptr <= wptr + FIFO_AW'(nq);
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && nq != 2'd0) begin
      fifo[wptr] <= q[0];
    end
    if (take && nq == 2'd2) begin
      fifo[wptr + 1'b1] <= q[1];
    end
  end

  assign out_valid = count != '0;
  assign token_kind = fifo[rptr].kind;
  assign token_length = fifo[rptr].length;
  assign nesting_depth = fifo[rptr].depth;
  assign status = fifo[rptr].status;
  assign last = fifo[rptr].last;

  `JSV_ASSERT_ALWAYS(a_err_parks_lexer, (err == 3'd0) || (lex == L_ERR))
  `JSV_ASSERT_ALWAYS(a_depth_bounded, depth <= DEPTH_CAP)
  `JSV_ASSERT_ALWAYS(a_queue_bounded, count <= (FIFO_AW + 1)'(FIFO_DEPTH))
  `JSV_ASSERT_NEXT(a_eod_clears, take && end_of_document, (depth == 8'd0) && (gst == G_TOP) && (err == 3'd0) && (lex == L_IDLE))

endmodule
